FILE: sv/pf_pkg.sv
// Playfair cipher package: letter and command codes, square geometry helpers.
// No dependencies; imported by playfair_digraph_cipher.
package pf_pkg;

  typedef logic [4:0] letter_t;
  typedef logic [4:0] cell_idx_t;
  typedef logic [2:0] cmd_t;

  localparam cmd_t CmdClear  = 3'd0;
  localparam cmd_t CmdKey    = 3'd1;
  localparam cmd_t CmdFinish = 3'd2;
  localparam cmd_t CmdText   = 3'd3;
  localparam cmd_t CmdEnd    = 3'd4;

  localparam int      NumLetters = 26;
  localparam int      NumCells   = 25;
  localparam letter_t LetI       = 5'd8;
  localparam letter_t LetJ       = 5'd9;
  localparam letter_t LetX       = 5'd23;
  localparam letter_t LetMax     = 5'd25;
  localparam cell_idx_t CellsFull = 5'd25;
  localparam logic [3:0] Side    = 4'd5;
  localparam logic [3:0] BackShift = 4'd4;

  typedef struct packed {
    logic [2:0] row;
    logic [2:0] col;
  } pf_rc_t;

  // cell index -> row/col; index is below 25
  function automatic pf_rc_t pf_rowcol(input cell_idx_t pos);
    pf_rc_t    rc;
    cell_idx_t base;
    if (pos >= 5'd20)      rc.row = 3'd4;
    else if (pos >= 5'd15) rc.row = 3'd3;
    else if (pos >= 5'd10) rc.row = 3'd2;
    else if (pos >= 5'd5)  rc.row = 3'd1;
    else                   rc.row = 3'd0;
    base   = {rc.row, 2'b00} + {2'b00, rc.row};
    rc.col = 3'(pos - base);
    return rc;
  endfunction

  // (v + shift) mod 5, shift is 1 or 4
  function automatic logic [2:0] pf_step(input logic [2:0] v, input logic dec);
    logic [3:0] s;
    s = {1'b0, v} + (dec ? BackShift : 4'd1);
    if (s >= Side) s = s - Side;
    return s[2:0];
  endfunction

  function automatic cell_idx_t pf_addr(input logic [2:0] row, input logic [2:0] col);
    return {row, 2'b00} + {2'b00, row} + {2'b00, col};
  endfunction

endpackage

FILE: sv/playfair_digraph_cipher.sv
// Playfair digraph cipher top level: key square and letter positions in RAM.
// Depends on pf_pkg.
//
// Usage:
//   Input beats carry a command on in_tuser (clear key, key letter, finish
//   key, text letter, end of text) and a letter code on in_tdata. Results are
//   letter pairs, one letter per out beat; out_tlast marks the second letter.
//   cfg_wr_data selects decrypt mode; write it only while the block is idle.
// Flow:
//   Clear, key letter, and an unpaired text letter leave the block idle.
//   Finish key sweeps the alphabet in ST_FILL before the next beat is taken.
//   A pair-forming beat reads the position RAM (two ports), then the square
//   RAM (two ports), then loads the output register; the next input beat
//   is taken once the block is back in idle after the square read.
//   Pair throughput is set by the two dependent RAM reads plus the 2-beat output.
// Stalls: results sit in an output register while the next input beat is
//   taken; a following pair waits at the square read until the output drains.
// Reset: clears the used-letter flags, fill count, pending letter and mode;
//   the square and position RAMs keep their contents and need no clearing.
module playfair_digraph_cipher
  import pf_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [4:0] letter, [7:5] zero
  input  logic [2:0] in_tuser,   // [2:0] command
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [4:0] out_letter, [7:5] zero
  output logic       out_tlast,  // last
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data // decrypt_mode
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_FILL = 4'b0010,
    ST_POS  = 4'b0100,
    ST_SQ   = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  letter_t   sq_mem  [NumCells];
  cell_idx_t pos_mem [NumLetters];

  logic [NumLetters-1:0] used_r, used_nxt;
  cell_idx_t fill_r, fill_nxt;
  letter_t   fill_idx_r, fill_idx_nxt;
  logic      pend_vld_r, pend_vld_nxt;
  letter_t   pend_let_r, pend_let_nxt;
  logic      mode_r;

  cell_idx_t pos_rd_a_r, pos_rd_b_r;
  letter_t   sq_rd_a_r, sq_rd_b_r;

  logic      out_vld_r, out_last_r;
  letter_t   out_l0_r, out_l1_r;

  logic      in_acc, out_acc;
  cmd_t      in_cmd;
  letter_t   in_let;
  logic      let_ok;
  logic      pair_go;
  letter_t   pair_b;

  logic      place_cand, place_used, place_do;
  letter_t   place_let;

  pf_rc_t    rc_a, rc_b;
  logic [2:0] ra, ca, rb, cb;
  cell_idx_t sq_addr_a, sq_addr_b;
  logic      sq_rd_go;

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_acc   = out_vld_r && out_tready;
  assign in_cmd    = in_tuser;
  assign in_let    = (in_tdata[4:0] == LetJ) ? LetI : in_tdata[4:0];
  assign let_ok    = (in_let <= LetMax);

  // pair decode at the input beat
  always_comb begin
    pair_go = 1'b0;
    pair_b  = LetX;
    case (in_cmd)
      CmdText: begin
        if (let_ok && pend_vld_r) begin
          pair_go = 1'b1;
          pair_b  = (!mode_r && (in_let == pend_let_r)) ? LetX : in_let;
        end
      end
      CmdEnd:  pair_go = pend_vld_r;
      default: pair_go = 1'b0;
    endcase
  end

  // key placement: single key letter or one step of the finish sweep
  always_comb begin
    place_cand = 1'b0;
    place_let  = fill_idx_r;
    if (state_r == ST_FILL) begin
      place_cand = (fill_idx_r != LetJ);
    end else if (in_acc && (in_cmd == CmdKey)) begin
      place_cand = let_ok;
      place_let  = in_let;
    end
    place_used = (place_let <= LetMax) ? used_r[place_let] : 1'b1;
    place_do   = place_cand && !place_used && (fill_r < CellsFull);
  end

  always_comb begin
    state_nxt    = state_r;
    used_nxt     = used_r;
    fill_nxt     = fill_r;
    fill_idx_nxt = fill_idx_r;
    pend_vld_nxt = pend_vld_r;
    pend_let_nxt = pend_let_r;

    if (place_do) begin
      used_nxt[place_let] = 1'b1;
      fill_nxt            = fill_r + 5'd1;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_cmd)
            CmdClear: begin
              used_nxt     = '0;
              fill_nxt     = '0;
              pend_vld_nxt = 1'b0;
              pend_let_nxt = '0;
            end
            CmdFinish: begin
              fill_idx_nxt = '0;
              state_nxt    = ST_FILL;
            end
            CmdText: begin
              if (let_ok) begin
                if (!pend_vld_r) begin
                  pend_vld_nxt = 1'b1;
                  pend_let_nxt = in_let;
                end else if (mode_r || in_let != pend_let_r) begin
                  // a doubled letter in encrypt mode stays pending
                  pend_vld_nxt = 1'b0;
                end
              end
            end
            CmdEnd:  pend_vld_nxt = 1'b0;
            default: pend_vld_nxt = pend_vld_r;
          endcase
          if (pair_go) state_nxt = ST_POS;
        end
      end
      ST_FILL: begin
        fill_idx_nxt = fill_idx_r + 5'd1;
        if (fill_idx_r == LetMax) state_nxt = ST_IDLE;
      end
      ST_POS: begin
        if (!out_vld_r) state_nxt = ST_SQ;
      end
      ST_SQ:   state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // position and square RAMs: one write port, two registered read ports each
  always_ff @(posedge clk) begin
    if (place_do) begin
      sq_mem[fill_r]     <= place_let;
      pos_mem[place_let] <= fill_r;
    end
    if (in_acc && pair_go) begin
      pos_rd_a_r <= pos_mem[pend_let_r];
      pos_rd_b_r <= pos_mem[pair_b];
    end
    if (sq_rd_go) begin
      sq_rd_a_r <= sq_mem[sq_addr_a];
      sq_rd_b_r <= sq_mem[sq_addr_b];
    end
  end

  // same row / same column / rectangle
  always_comb begin
    rc_a = pf_rowcol(pos_rd_a_r);
    rc_b = pf_rowcol(pos_rd_b_r);
    ra = rc_a.row;
    ca = rc_a.col;
    rb = rc_b.row;
    cb = rc_b.col;
    if (rc_a.row == rc_b.row) begin
      ca = pf_step(rc_a.col, mode_r);
      cb = pf_step(rc_b.col, mode_r);
    end else if (rc_a.col == rc_b.col) begin
      ra = pf_step(rc_a.row, mode_r);
      rb = pf_step(rc_b.row, mode_r);
    end else begin
      ca = rc_b.col;
      cb = rc_a.col;
    end
    sq_addr_a = pf_addr(ra, ca);
    sq_addr_b = pf_addr(rb, cb);
    sq_rd_go  = (state_r == ST_POS) && !out_vld_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      used_r     <= '0;
      fill_r     <= '0;
      fill_idx_r <= '0;
      pend_vld_r <= 1'b0;
      pend_let_r <= '0;
      mode_r     <= 1'b0;
      out_vld_r  <= 1'b0;
      out_last_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      used_r     <= used_nxt;
      fill_r     <= fill_nxt;
      fill_idx_r <= fill_idx_nxt;
      pend_vld_r <= pend_vld_nxt;
      pend_let_r <= pend_let_nxt;
      if (cfg_wr_en) mode_r <= cfg_wr_data;
      if (state_r == ST_SQ) begin
        out_vld_r  <= 1'b1;
        out_last_r <= 1'b0;
      end else if (out_acc) begin
        out_vld_r  <= !out_last_r;
        out_last_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_SQ) begin
      out_l0_r <= sq_rd_a_r;
      out_l1_r <= sq_rd_b_r;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {3'b000, (out_last_r ? out_l1_r : out_l0_r)};

endmodule

FILE: sv/pf_chk.sv
// Port-level checker for playfair_digraph_cipher, attached with bind.
// No package dependencies.
module pf_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("out beat changed while stalled");

  a_pair_second: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=> out_tvalid && out_tlast)
    else $error("first letter of pair not followed by second");

  a_pair_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tlast |=> !out_tvalid)
    else $error("new pair shown right after a pair end");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("block not idle after reset");

endmodule

bind playfair_digraph_cipher pf_chk u_pf_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
